>>> rtl/bmcrf_pkg.sv
// Shared types and constants for the binary mask column/row fill unit.
// No dependencies.
package bmcrf_pkg;

    // Command codes carried by the command field of an input word
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Configuration register indexes (byte address = 4 * index)
    localparam int unsigned REG_IMAGE_WIDTH  = 0;
    localparam int unsigned REG_IMAGE_HEIGHT = 1;

    localparam int unsigned CFG_SIZE_W   = 10;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_ADDR_W   = 3;

    // Register reset values
    localparam logic [CFG_SIZE_W-1:0] IMAGE_WIDTH_RST  = 10'd512;
    localparam logic [CFG_SIZE_W-1:0] IMAGE_HEIGHT_RST = 10'd512;

endpackage

>>> rtl/binary_mask_column_row_fill_unit.sv
// Binary mask column/row span fill unit. Depends on bmcrf_pkg.
// Pixel write: one word per cycle. Pixel read: the bit is registered, then sent when the
// output slot is free; no new word is taken until then. Fill: per pass and per line, n reads,
// a turnaround state and span writes on one single-port-read frame store, then a done word.
// Reset (rst_n low, async): image sizes return to 512, control clears; the
// frame store is not cleared and holds undefined data until written.
module binary_mask_column_row_fill_unit #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bmcrf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bmcrf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bmcrf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready,
    // input words
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic [8:0]                           column,
    input  logic [8:0]                           row,
    input  logic                                 pixel_white,
    // result words
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 read_white,
    output logic                                 fill_done
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned XCW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YCW   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned NW    = (XCW > YCW) ? XCW : YCW;
    localparam int unsigned SW    = bmcrf_pkg::CFG_SIZE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_SCAN,
        ST_WAIT,
        ST_FILL,
        ST_DONE
    } state_t;

    // Frame store address of pixel (x, y)
    function automatic logic [AW-1:0] pix_addr(input logic [NW-1:0] x, input logic [NW-1:0] y);
        pix_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // registers
    state_t          state_reg, state_next;
    logic [SW-1:0]   image_width_reg, image_height_reg;
    logic            pass_row_reg, pass_row_next;
    logic [NW-1:0]   outer_reg, outer_next;
    logic [NW-1:0]   inner_reg, inner_next;
    logic            rd_pend_reg, rd_pend_next;
    logic [NW-1:0]   rd_idx_reg, rd_idx_next;
    logic            found_reg, found_next;
    logic [NW-1:0]   first_reg, first_next;
    logic [NW-1:0]   last_reg, last_next;
    logic            rd_zero_reg, rd_zero_next;
    logic            out_valid_reg, out_valid_next;
    logic            read_white_reg, read_white_next;
    logic            fill_done_reg, fill_done_next;

    // frame store
    logic            frame_mem [DEPTH];
    logic            mem_q;
    logic            mem_we, mem_re, mem_wdata;
    logic [AW-1:0]   mem_waddr, mem_raddr;

    // derived
    logic [NW-1:0]   w_use, h_use, lim_in, lim_out;
    logic [AW-1:0]   in_addr, cur_addr;
    logic            in_inside, slot_free;
    logic            found_upd;
    logic [NW-1:0]   first_upd, last_upd;
    logic            cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        if (paddr[2] == 1'(bmcrf_pkg::REG_IMAGE_HEIGHT))
            prdata = bmcrf_pkg::CFG_DATA_W'(image_height_reg);
        else
            prdata = bmcrf_pkg::CFG_DATA_W'(image_width_reg);
    end

    // Active region, clamped to the store size
    always_comb
    begin
        if (32'(image_width_reg) > MAX_WIDTH)
            w_use = NW'(MAX_WIDTH);
        else
            w_use = NW'(image_width_reg);
        if (32'(image_height_reg) > MAX_HEIGHT)
            h_use = NW'(MAX_HEIGHT);
        else
            h_use = NW'(image_height_reg);
    end

    assign lim_in    = pass_row_reg ? w_use : h_use;
    assign lim_out   = pass_row_reg ? h_use : w_use;
    assign cur_addr  = pass_row_reg ? pix_addr(inner_reg, outer_reg)
                                    : pix_addr(outer_reg, inner_reg);
    assign in_inside = (32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
    assign in_addr   = AW'(32'(row) * MAX_WIDTH + 32'(column));
    assign slot_free = !out_valid_reg || out_ready;

    // Span tracking on returning scan data
    always_comb
    begin
        found_upd = found_reg;
        first_upd = first_reg;
        last_upd  = last_reg;
        if (rd_pend_reg && mem_q)
        begin
            if (!found_reg)
                first_upd = rd_idx_reg;
            found_upd = 1'b1;
            last_upd  = rd_idx_reg;
        end
    end

    // Control and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        pass_row_next   = pass_row_reg;
        outer_next      = outer_reg;
        inner_next      = inner_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_upd;
        first_next      = first_upd;
        last_next       = last_upd;
        rd_zero_next    = rd_zero_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_white_next = read_white_reg;
        fill_done_next  = fill_done_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = 1'b1;
        mem_waddr       = cur_addr;
        mem_raddr       = cur_addr;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (bmcrf_pkg::cmd_t'(command))
                        bmcrf_pkg::CMD_WRITE:
                        begin
                            mem_we    = in_inside;
                            mem_waddr = in_addr;
                            mem_wdata = pixel_white;
                        end
                        bmcrf_pkg::CMD_READ:
                        begin
                            mem_re       = in_inside;
                            mem_raddr    = in_addr;
                            rd_zero_next = !in_inside;
                            state_next   = ST_RDWAIT;
                        end
                        bmcrf_pkg::CMD_FILL:
                        begin
                            pass_row_next = 1'b0;
                            outer_next    = '0;
                            inner_next    = '0;
                            found_next    = 1'b0;
                            if (w_use == '0 || h_use == '0)
                                state_next = ST_DONE;
                            else
                                state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    read_white_next = !rd_zero_reg && mem_q;
                    fill_done_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            // read one line, one pixel a cycle
            ST_SCAN:
            begin
                mem_re       = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = inner_reg;
                if (inner_reg == lim_in - 1'b1)
                    state_next = ST_WAIT;
                else
                    inner_next = inner_reg + 1'b1;
            end

            // last pixel of the line lands; start the span or move on
            ST_WAIT:
            begin
                if (found_upd)
                begin
                    inner_next = first_upd;
                    state_next = ST_FILL;
                end
                else
                begin
                    found_next = 1'b0;
                    inner_next = '0;
                    if (outer_reg == lim_out - 1'b1)
                    begin
                        outer_next = '0;
                        if (pass_row_reg)
                            state_next = ST_DONE;
                        else
                        begin
                            pass_row_next = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    else
                    begin
                        outer_next = outer_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            // whiten the span first..last of the line
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                if (inner_reg == last_reg)
                begin
                    found_next = 1'b0;
                    inner_next = '0;
                    if (outer_reg == lim_out - 1'b1)
                    begin
                        outer_next = '0;
                        if (pass_row_reg)
                            state_next = ST_DONE;
                        else
                        begin
                            pass_row_next = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    else
                    begin
                        outer_next = outer_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else
                    inner_next = inner_reg + 1'b1;
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    read_white_next = 1'b0;
                    fill_done_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters, config registers and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= bmcrf_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= bmcrf_pkg::IMAGE_HEIGHT_RST;
            pass_row_reg     <= 1'b0;
            outer_reg        <= '0;
            inner_reg        <= '0;
            rd_pend_reg      <= 1'b0;
            rd_idx_reg       <= '0;
            found_reg        <= 1'b0;
            first_reg        <= '0;
            last_reg         <= '0;
            rd_zero_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            read_white_reg   <= 1'b0;
            fill_done_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_row_reg   <= pass_row_next;
            outer_reg      <= outer_next;
            inner_reg      <= inner_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            found_reg      <= found_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            rd_zero_reg    <= rd_zero_next;
            out_valid_reg  <= out_valid_next;
            read_white_reg <= read_white_next;
            fill_done_reg  <= fill_done_next;
            if (cfg_wr)
            begin
                if (paddr[2] == 1'(bmcrf_pkg::REG_IMAGE_HEIGHT))
                    image_height_reg <= pwdata[SW-1:0];
                else
                    image_width_reg <= pwdata[SW-1:0];
            end
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= frame_mem[mem_raddr];
    end

    assign out_valid  = out_valid_reg;
    assign read_white = read_white_reg;
    assign fill_done  = fill_done_reg;

endmodule

>>> verif/testbench.sv
// Testbench for binary_mask_column_row_fill_unit: sends pixel, fill and read words and
// checks every reply against a local image of the frame store kept in step with them.
// Depends on bmcrf_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned FRAME_W      = 512;
    localparam int unsigned FRAME_H      = 512;
    localparam int unsigned FRAME_PIX    = FRAME_W * FRAME_H;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned WAIT_MAX     = 18;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned TAIL         = 40;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned TOTAL_WORDS  = 1800;
    localparam int unsigned MAX_PRINTS   = 100;

    // one reply word
    typedef struct packed {
        logic read_white;
        logic fill_done;
    } mask_reply_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [bmcrf_pkg::CFG_ADDR_W-1:0] paddr       = '0;
    logic [bmcrf_pkg::CFG_DATA_W-1:0] pwdata      = '0;
    logic [bmcrf_pkg::CFG_DATA_W-1:0] prdata;
    logic                             pready;
    logic                             in_valid    = 1'b0;
    logic                             in_ready;
    logic [1:0]                       command     = bmcrf_pkg::CMD_WRITE;
    logic [8:0]                       column      = '0;
    logic [8:0]                       row         = '0;
    logic                             pixel_white = 1'b0;
    logic                             out_valid;
    logic                             out_ready   = 1'b0;
    logic                             read_white;
    logic                             fill_done;

    // local frame image, which pixels hold data, and the sizes in use
    bit                               frame_img   [FRAME_PIX];
    bit                               frame_known [FRAME_PIX];
    int unsigned                      known_list  [$];
    logic [bmcrf_pkg::CFG_SIZE_W-1:0] size_w = bmcrf_pkg::IMAGE_WIDTH_RST;
    logic [bmcrf_pkg::CFG_SIZE_W-1:0] size_h = bmcrf_pkg::IMAGE_HEIGHT_RST;

    mask_reply_t           reply_queue [$];
    int unsigned           err_count      = 0;
    int unsigned           words_sent     = 0;
    int unsigned           cycles         = 0;
    bit                    sender_quiet   = 1'b0;
    bit                    receiver_quiet = 1'b0;

    binary_mask_column_row_fill_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .column      (column),
        .row         (row),
        .pixel_white (pixel_white),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_white  (read_white),
        .fill_done   (fill_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned pix_at(input int unsigned col, input int unsigned rw);
        return rw * FRAME_W + col;
    endfunction

    // sizes above the store act as the store size
    function automatic int unsigned clamp_dim(input logic [bmcrf_pkg::CFG_SIZE_W-1:0] v,
                                              input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // column pass, then row pass over the active region
    function automatic void span_fill_predict();
        int unsigned w, h, x, y, lo, hi;
        bit          found;
        w = clamp_dim(size_w, FRAME_W);
        h = clamp_dim(size_h, FRAME_H);
        for (x = 0; x < w; x++)
        begin
            found = 1'b0;
            lo = 0;
            hi = 0;
            for (y = 0; y < h; y++)
            begin
                if (frame_img[pix_at(x, y)])
                begin
                    if (!found)
                        lo = y;
                    found = 1'b1;
                    hi = y;
                end
            end
            if (found)
                for (y = lo; y <= hi; y++)
                    frame_img[pix_at(x, y)] = 1'b1;
        end
        for (y = 0; y < h; y++)
        begin
            found = 1'b0;
            lo = 0;
            hi = 0;
            for (x = 0; x < w; x++)
            begin
                if (frame_img[pix_at(x, y)])
                begin
                    if (!found)
                        lo = x;
                    found = 1'b1;
                    hi = x;
                end
            end
            if (found)
                for (x = lo; x <= hi; x++)
                    frame_img[pix_at(x, y)] = 1'b1;
        end
    endfunction

    // update the image for one accepted word and queue its reply, if any
    function automatic void mask_word_predict(input logic [1:0] cmd, input logic [8:0] col,
                                              input logic [8:0] rw, input logic white);
        int unsigned idx;
        idx = pix_at(col, rw);
        case (cmd)
            bmcrf_pkg::CMD_WRITE:
            begin
                frame_img[idx] = white;
                if (!frame_known[idx])
                begin
                    frame_known[idx] = 1'b1;
                    known_list.push_back(idx);
                end
            end
            bmcrf_pkg::CMD_FILL:
            begin
                span_fill_predict();
                reply_queue.push_back(mask_reply_t'{read_white: 1'b0, fill_done: 1'b1});
            end
            bmcrf_pkg::CMD_READ:
                reply_queue.push_back(mask_reply_t'{read_white: frame_img[idx], fill_done: 1'b0});
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_reply(input logic got_white, input logic got_done);
        mask_reply_t want;
        if (reply_queue.size() == 0)
        begin
            report_mismatch("reply word with nothing pending");
            return;
        end
        want = reply_queue.pop_front();
        if (got_white !== want.read_white)
            report_mismatch($sformatf("read_white %b, want %b", got_white, want.read_white));
        if (got_done !== want.fill_done)
            report_mismatch($sformatf("fill_done %b, want %b", got_done, want.fill_done));
    endtask

    // send one word; entered and left just after a rising edge
    task automatic send_word(input logic [1:0] cmd, input int unsigned col,
                             input int unsigned rw, input logic white);
        int unsigned gap;
        gap = draw_wait(sender_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        column      <= 9'(col);
        row         <= 9'(rw);
        pixel_white <= white;
        do @(posedge clk); while (!in_ready);
        mask_word_predict(cmd, 9'(col), 9'(rw), white);
        words_sent++;
    endtask

    // hold the input side until every reply has come back
    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (reply_queue.size() != 0);
    endtask

    task automatic apb_cycle(input int unsigned index, input logic wr,
                             input logic [bmcrf_pkg::CFG_DATA_W-1:0] data,
                             output logic [bmcrf_pkg::CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= bmcrf_pkg::CFG_ADDR_W'(4 * index);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write a size register and read it back
    task automatic set_size(input int unsigned index, input int unsigned value);
        logic [bmcrf_pkg::CFG_DATA_W-1:0] rdata;
        apb_cycle(index, 1'b1, bmcrf_pkg::CFG_DATA_W'(value), rdata);
        if (index == bmcrf_pkg::REG_IMAGE_WIDTH)
            size_w = bmcrf_pkg::CFG_SIZE_W'(value);
        else
            size_h = bmcrf_pkg::CFG_SIZE_W'(value);
        apb_cycle(index, 1'b0, '0, rdata);
        if (rdata != bmcrf_pkg::CFG_DATA_W'(value))
            report_mismatch($sformatf("register %0d reads %0d, wrote %0d", index, rdata, value));
    endtask

    // sizes change only once the unit has gone quiet
    task automatic configure(input int unsigned w, input int unsigned h);
        drain_replies();
        repeat (SETTLE) @(posedge clk);
        set_size(bmcrf_pkg::REG_IMAGE_WIDTH, w);
        set_size(bmcrf_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // the fill reads the whole active region, so give every pixel there a value first
    task automatic run_fill(input int unsigned pct);
        int unsigned w, h, x, y;
        w = clamp_dim(size_w, FRAME_W);
        h = clamp_dim(size_h, FRAME_H);
        for (y = 0; y < h; y++)
            for (x = 0; x < w; x++)
                if (!frame_known[pix_at(x, y)])
                    send_word(bmcrf_pkg::CMD_WRITE, x, y, $urandom_range(0, 99) < pct);
        send_word(bmcrf_pkg::CMD_FILL, $urandom_range(0, FRAME_W - 1),
                  $urandom_range(0, FRAME_H - 1), $urandom_range(0, 1));
    endtask

    // read back a pixel that already holds data
    task automatic read_known();
        int unsigned idx;
        if (known_list.size() == 0)
            return;
        idx = known_list[$urandom_range(0, known_list.size() - 1)];
        send_word(bmcrf_pkg::CMD_READ, idx % FRAME_W, idx / FRAME_W, $urandom_range(0, 1));
    endtask

    task automatic test_register_reset();
        logic [bmcrf_pkg::CFG_DATA_W-1:0] rdata;
        apb_cycle(bmcrf_pkg::REG_IMAGE_WIDTH, 1'b0, '0, rdata);
        if (rdata != bmcrf_pkg::CFG_DATA_W'(bmcrf_pkg::IMAGE_WIDTH_RST))
            report_mismatch($sformatf("image_width resets to %0d", rdata));
        apb_cycle(bmcrf_pkg::REG_IMAGE_HEIGHT, 1'b0, '0, rdata);
        if (rdata != bmcrf_pkg::CFG_DATA_W'(bmcrf_pkg::IMAGE_HEIGHT_RST))
            report_mismatch($sformatf("image_height resets to %0d", rdata));
    endtask

    // small mask with a hole in column 0 and two empty columns
    task automatic test_directed_cases();
        logic [11:0] glint_mask;
        int unsigned x, y;
        glint_mask = 12'b1001_0000_0001;
        configure(4, 3);
        for (y = 0; y < 3; y++)
            for (x = 0; x < 4; x++)
                send_word(bmcrf_pkg::CMD_WRITE, x, y, glint_mask[y * 4 + x]);
        // far corner lies outside the active region and must survive the fill
        send_word(bmcrf_pkg::CMD_WRITE, FRAME_W - 1, FRAME_H - 1, 1'b1);
        send_word(bmcrf_pkg::CMD_READ, FRAME_W - 1, FRAME_H - 1, 1'b0);
        // unused command must not touch the pixel
        send_word(CMD_UNUSED, 0, 0, 1'b0);
        send_word(bmcrf_pkg::CMD_READ, 0, 0, 1'b1);
        send_word(bmcrf_pkg::CMD_READ, 0, 1, 1'b0);
        send_word(bmcrf_pkg::CMD_FILL, 0, 0, 1'b0);
        send_word(bmcrf_pkg::CMD_READ, 0, 1, 1'b0);
        send_word(bmcrf_pkg::CMD_READ, 1, 2, 1'b1);
        send_word(bmcrf_pkg::CMD_READ, 1, 0, 1'b0);
        send_word(bmcrf_pkg::CMD_READ, 3, 0, 1'b1);
        send_word(bmcrf_pkg::CMD_READ, FRAME_W - 1, FRAME_H - 1, 1'b0);
    endtask

    // zero sizes, sizes above the store, single row and single column
    task automatic test_size_extremes();
        configure(0, FRAME_H);
        run_fill(0);
        send_word(bmcrf_pkg::CMD_READ, 1, 0, 1'b0);
        configure(FRAME_W, 0);
        run_fill(0);
        send_word(bmcrf_pkg::CMD_READ, 2, 1, 1'b0);
        configure(1023, 1);
        run_fill(2);
        repeat (6) read_known();
        configure(1, 1023);
        run_fill(2);
        repeat (6) read_known();
        configure(1, 1);
        run_fill(50);
        send_word(bmcrf_pkg::CMD_READ, 0, 0, 1'b0);
    endtask

    // phases of random masks, each closed by a fill and reads of the region
    task automatic test_random_traffic();
        int unsigned phase_words, roll, w, h, t, pct;
        while (words_sent < TOTAL_WORDS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 4);
                if ($urandom_range(0, 1))
                begin
                    t = w;
                    w = h;
                    h = t;
                end
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
            end
            configure(w, h);
            pct = 5 + 20 * $urandom_range(0, 4);
            sender_quiet = ($urandom_range(0, 3) == 0);
            phase_words = $urandom_range(40, 160);
            repeat (phase_words)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    send_word(bmcrf_pkg::CMD_WRITE, $urandom_range(0, w - 1),
                              $urandom_range(0, h - 1), $urandom_range(0, 99) < pct);
                else if (roll < 60)
                    send_word(bmcrf_pkg::CMD_WRITE, $urandom_range(0, FRAME_W - 1),
                              $urandom_range(0, FRAME_H - 1), $urandom_range(0, 1));
                else if (roll < 82)
                    read_known();
                else if (roll < 87)
                    send_word(CMD_UNUSED, $urandom_range(0, FRAME_W - 1),
                              $urandom_range(0, FRAME_H - 1), $urandom_range(0, 1));
                else if (roll < 95)
                    run_fill(pct);
                else
                    drain_replies();
            end
            run_fill(pct);
            repeat (8)
                send_word(bmcrf_pkg::CMD_READ, $urandom_range(0, w - 1),
                          $urandom_range(0, h - 1), $urandom_range(0, 1));
        end
        sender_quiet = 1'b0;
    endtask

    // reply side: random stalls, checks each word taken
    initial
    begin : reply_sink
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(receiver_quiet);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 29) == 0)
                receiver_quiet = !receiver_quiet;
            check_reply(read_white, fill_done);
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset();
        test_directed_cases();
        test_size_extremes();
        test_random_traffic();
        drain_replies();
        repeat (TAIL) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
